// ===== design/rhd_pkg.sv =====
`default_nettype none
// rhd_pkg: types, constants and arithmetic helpers for the ramped heading-hold drive.
// No dependencies; the top level, rhd_step, rhd_core and rhd_finish import it.

package rhd_pkg;

   typedef enum logic [1:0] {
      KIND_TANK     = 2'd0,
      KIND_BEGIN    = 2'd1,
      KIND_CONTINUE = 2'd2,
      KIND_RESET    = 2'd3
   } rhd_kind_type;

   // csr register indexes
   localparam logic [2:0] CSR_STABLE_MODE   = 3'd0;
   localparam logic [2:0] CSR_FWD_STABLE    = 3'd1;
   localparam logic [2:0] CSR_FWD_TIPPY     = 3'd2;
   localparam logic [2:0] CSR_REV_STABLE    = 3'd3;
   localparam logic [2:0] CSR_REV_TIPPY     = 3'd4;

   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 18;

   localparam logic [19:0] US_PER_S       = 20'd1000000;
   localparam logic [9:0]  US_PER_MS      = 10'd1000;
   localparam logic signed [18:0] ABORT_ERR = 19'sd11520;  // 90 degrees
   localparam logic signed [18:0] OFF_ERR   = 19'sd3840;   // 30 degrees
   localparam logic [20:0] OFF_SAT        = 21'h1FFFFF;
   localparam logic [10:0] CURVE_MAX      = 11'd1638;
   // magnitudes above the knee always clamp to CURVE_MAX
   localparam logic [10:0] CURVE_KNEE     = 11'd1280;

   // reciprocals: floor(x/d) = (x * M) >> S over the stated input range
   localparam logic [32:0] RECIP_15625   = 33'd4503599628;  // x < 2**32, S = 46
   localparam logic [16:0] RECIP_25      = 17'd83887;       // x < 2**16, S = 21
   localparam logic [24:0] RECIP_125     = 25'd17179870;    // x < 2**24, S = 31

   localparam logic [17:0] RST_FWD_STABLE = 18'd16384;
   localparam logic [17:0] RST_FWD_TIPPY  = 18'd8192;
   localparam logic [17:0] RST_REV_STABLE = 18'd16384;
   localparam logic [17:0] RST_REV_TIPPY  = 18'd8192;

   typedef struct packed {
      logic        stable;
      logic [17:0] fwd_stable;
      logic [17:0] fwd_tippy;
      logic [17:0] rev_stable;
      logic [17:0] rev_tippy;
   } rhd_cfg_type;

   // one tick, elapsed time already clamped to one second
   typedef struct packed {
      rhd_kind_type       kind;
      logic [19:0]        elapsed;
      logic signed [17:0] gyro;
      logic signed [17:0] target;
      logic signed [15:0] max_out;
      logic [15:0]        dur_ms;
      logic signed [15:0] left;
      logic signed [15:0] right;
   } rhd_item_type;

   // tick plus its two ramp steps
   // tank: a = left step, b = right step; straight: a = forward, b = reverse
   typedef struct packed {
      rhd_item_type item;
      logic [17:0]  step_a;
      logic [17:0]  step_b;
   } rhd_stepped_type;

   // state-stage result, finished by rhd_finish
   typedef struct packed {
      logic               active;
      logic               aborted;
      logic signed [15:0] speed;
      logic signed [15:0] left;
      logic signed [15:0] right;
      logic [10:0]        mag;
      logic               neg;
      logic [25:0]        rest_us;
   } rhd_pre_type;

   // rate * elapsed / 1e6, via /64 then reciprocal of 15625
   function automatic logic [17:0] rhd_div_mega(input logic [37:0] prod);
      logic [31:0] y;
      logic [64:0] p;
      y = prod[37:6];
      p = 65'(y) * 65'(RECIP_15625);
      return p[63:46];
   endfunction

   // min(mag * 32 / 25, CURVE_MAX), mag already limited to CURVE_KNEE + 1
   function automatic logic [10:0] rhd_curve(input logic [10:0] mag);
      logic [15:0] x;
      logic [32:0] p;
      logic [10:0] q;
      x = {mag, 5'b0};
      p = 33'(x) * 33'(RECIP_25);
      q = p[31:21];
      return (q > CURVE_MAX) ? CURVE_MAX : q;
   endfunction

   // ceil(rest_us / 1000)
   function automatic logic [15:0] rhd_ceil_ms(input logic [25:0] rest_us);
      logic [26:0] z;
      logic [23:0] w;
      logic [48:0] p;
      z = 27'(rest_us) + 27'(US_PER_MS - 10'd1);
      w = z[26:3];
      p = 49'(w) * 49'(RECIP_125);
      return p[46:31];
   endfunction

   // slew limiter: move cur toward target, double step when slowing down
   function automatic logic signed [15:0] rhd_ramp(input logic signed [15:0] target,
                                                   input logic signed [15:0] cur,
                                                   input logic [17:0] step);
      logic               fwd;
      logic               up;
      logic [18:0]        amt;
      logic signed [20:0] t;
      logic signed [20:0] c;
      logic signed [20:0] a;
      logic signed [20:0] nxt;
      fwd = !target[15];
      up  = cur < target;
      amt = (up ^ fwd) ? {step, 1'b0} : {1'b0, step};
      t   = {{5{target[15]}}, target};
      c   = {{5{cur[15]}}, cur};
      a   = $signed({2'b00, amt});
      nxt = c;
      if (cur != target) begin
         if (up) begin
            nxt = c + a;
            if (nxt > t) nxt = t;
         end else begin
            nxt = c - a;
            if (nxt < t) nxt = t;
         end
      end
      return nxt[15:0];
   endfunction

endpackage

`default_nettype wire

// ===== design/rhd_req_if.sv =====
`default_nettype none
// rhd_req_if: tick channel (valid, ready, tick fields).
// Depends on nothing.

interface rhd_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic [19:0]        elapsed_us;
   logic signed [17:0] gyro_angle;
   logic signed [17:0] target_angle;
   logic signed [15:0] max_output;
   logic [15:0]        duration_ms;
   logic signed [15:0] left_throttle;
   logic signed [15:0] right_throttle;

   modport source (output valid, kind, elapsed_us, gyro_angle, target_angle, max_output,
                   duration_ms, left_throttle, right_throttle, input ready);
   modport sink   (input valid, kind, elapsed_us, gyro_angle, target_angle, max_output,
                   duration_ms, left_throttle, right_throttle, output ready);
endinterface

`default_nettype wire

// ===== design/rhd_rsp_if.sv =====
`default_nettype none
// rhd_rsp_if: result channel (valid, ready, drive commands).
// Depends on nothing.

interface rhd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] out_speed;
   logic signed [11:0] out_curve;
   logic signed [15:0] out_left;
   logic signed [15:0] out_right;
   logic [15:0]        remaining_ms;
   logic               aborted;

   modport source (output valid, out_speed, out_curve, out_left, out_right, remaining_ms,
                   aborted, input ready);
   modport sink   (input valid, out_speed, out_curve, out_left, out_right, remaining_ms,
                   aborted, output ready);
endinterface

`default_nettype wire

// ===== design/ramped_heading_hold_drive.sv =====
`default_nettype none
// ramped_heading_hold_drive: top level, tick input register, csr bank, pipeline wiring.
// Depends on rhd_pkg, rhd_req_if, rhd_rsp_if, rhd_step, rhd_core, rhd_finish.

// Slew-rate limited tank drive with a straight-line heading hold. Every tick
// transfer on req_bus yields exactly one result transfer on rsp_bus, in order.
// Throughput is one tick per clock while rsp_bus takes results. A tick passes
// the input register, rate*time product, divide by 1e6, state update, and
// curve and remaining-time finish before its result appears. All drive state
// is read and written in the single state-update stage, so ticks may follow
// each other in consecutive cycles. Each stage holds its item under
// backpressure and takes new work only when empty or its item moves on.
// Rates and stable_mode come from the csr write port and should only change
// while no tick is in flight. No clearing pass is needed after reset.

module ramped_heading_hold_drive (
   input  wire logic                           clock,
   input  wire logic                           reset,
   rhd_req_if.sink                             req_bus,
   rhd_rsp_if.source                           rsp_bus,
   input  wire logic                           csr_we,
   input  wire logic [rhd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [rhd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rhd_pkg::*;

   rhd_cfg_type     cfg_ff;
   logic            s0_valid_ff;
   rhd_item_type    s0_ff, s0_in;
   logic            step_ready;
   logic            step_valid;
   rhd_stepped_type step_data;
   logic            core_ready;
   logic            pre_valid;
   rhd_pre_type     pre_data;
   logic            finish_ready;
   logic            s0_load;

   // csr bank; out-of-range indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stable     <= 1'b1;
         cfg_ff.fwd_stable <= RST_FWD_STABLE;
         cfg_ff.fwd_tippy  <= RST_FWD_TIPPY;
         cfg_ff.rev_stable <= RST_REV_STABLE;
         cfg_ff.rev_tippy  <= RST_REV_TIPPY;
      end else if (csr_we) begin
         case (csr_index)
            CSR_STABLE_MODE: cfg_ff.stable     <= csr_wdata[0];
            CSR_FWD_STABLE:  cfg_ff.fwd_stable <= csr_wdata;
            CSR_FWD_TIPPY:   cfg_ff.fwd_tippy  <= csr_wdata;
            CSR_REV_STABLE:  cfg_ff.rev_stable <= csr_wdata;
            CSR_REV_TIPPY:   cfg_ff.rev_tippy  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register; elapsed time clamped to one second on the way in
   assign s0_load       = !s0_valid_ff || step_ready;
   assign req_bus.ready = s0_load;

   always_comb begin
      s0_in.kind    = rhd_kind_type'(req_bus.kind);
      s0_in.elapsed = (req_bus.elapsed_us > US_PER_S) ? US_PER_S : req_bus.elapsed_us;
      s0_in.gyro    = req_bus.gyro_angle;
      s0_in.target  = req_bus.target_angle;
      s0_in.max_out = req_bus.max_output;
      s0_in.dur_ms  = req_bus.duration_ms;
      s0_in.left    = req_bus.left_throttle;
      s0_in.right   = req_bus.right_throttle;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (s0_load) begin
         s0_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_load && req_bus.valid) s0_ff <= s0_in;
   end

   // ramp steps: rate selection and the per-second scaling
   rhd_step u_step (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (s0_valid_ff),
      .in_item   (s0_ff),
      .in_ready  (step_ready),
      .out_valid (step_valid),
      .out_data  (step_data),
      .out_ready (core_ready)
   );

   // drive state update
   rhd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (step_valid),
      .in_data   (step_data),
      .in_ready  (core_ready),
      .out_valid (pre_valid),
      .out_data  (pre_data),
      .out_ready (finish_ready)
   );

   // curve and remaining-time scaling, result register
   rhd_finish u_finish (
      .clock    (clock),
      .reset    (reset),
      .in_valid (pre_valid),
      .in_data  (pre_data),
      .in_ready (finish_ready),
      .rsp_bus  (rsp_bus)
   );

endmodule

`default_nettype wire

// ===== design/rhd_step.sv =====
`default_nettype none
// rhd_step: two-stage ramp step pipeline (rate * elapsed, then divide by 1e6).
// Depends on rhd_pkg.

module rhd_step (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire rhd_pkg::rhd_cfg_type   cfg,
   input  wire logic                   in_valid,
   input  wire rhd_pkg::rhd_item_type  in_item,
   output logic                        in_ready,
   output logic                        out_valid,
   output rhd_pkg::rhd_stepped_type    out_data,
   input  wire logic                   out_ready
);
   import rhd_pkg::*;

   typedef struct packed {
      rhd_item_type item;
      logic [37:0]  prod_a;
      logic [37:0]  prod_b;
   } rhd_prod_type;

   logic            s1_valid_ff, s1_valid_in;
   rhd_prod_type    s1_ff, s1_in;
   logic            s2_valid_ff, s2_valid_in;
   rhd_stepped_type s2_ff, s2_in;
   logic            s1_load, s2_load;
   logic [17:0]     fwd_rate, rev_rate, rate_a, rate_b;

   assign s2_load  = !s2_valid_ff || out_ready;
   assign s1_load  = !s1_valid_ff || s2_load;
   assign in_ready = s1_load;

   always_comb begin
      fwd_rate = cfg.stable ? cfg.fwd_stable : cfg.fwd_tippy;
      rev_rate = cfg.stable ? cfg.rev_stable : cfg.rev_tippy;
      if (in_item.kind == KIND_TANK) begin
         rate_a = in_item.left[15]  ? rev_rate : fwd_rate;
         rate_b = in_item.right[15] ? rev_rate : fwd_rate;
      end else begin
         rate_a = fwd_rate;
         rate_b = rev_rate;
      end
      s1_in.item   = in_item;
      s1_in.prod_a = 38'(rate_a) * 38'(in_item.elapsed);
      s1_in.prod_b = 38'(rate_b) * 38'(in_item.elapsed);
      s1_valid_in  = in_valid;

      s2_in.item   = s1_ff.item;
      s2_in.step_a = rhd_div_mega(s1_ff.prod_a);
      s2_in.step_b = rhd_div_mega(s1_ff.prod_b);
      s2_valid_in  = s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_load) s1_valid_ff <= s1_valid_in;
         if (s2_load) s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load && in_valid)    s1_ff <= s1_in;
      if (s2_load && s1_valid_ff) s2_ff <= s2_in;
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_ff;

endmodule

`default_nettype wire

// ===== design/rhd_core.sv =====
`default_nettype none
// rhd_core: drive state (levels, held values, timers) and per-tick update.
// Depends on rhd_pkg.

module rhd_core (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   input  wire rhd_pkg::rhd_stepped_type in_data,
   output logic                          in_ready,
   output logic                          out_valid,
   output rhd_pkg::rhd_pre_type          out_data,
   input  wire logic                     out_ready
);
   import rhd_pkg::*;

   logic signed [15:0] sl_ff, sl_in;
   logic signed [15:0] left_ff, left_in;
   logic signed [15:0] right_ff, right_in;
   logic signed [17:0] hd_ff, hd_in;
   logic signed [15:0] hs_ff, hs_in;
   logic [15:0]        hdur_ff, hdur_in;
   logic [31:0]        dt_ff, dt_in;
   logic               dt_on_ff, dt_on_in;
   logic [20:0]        ot_ff, ot_in;
   logic               ot_on_ff, ot_on_in;
   logic               pre_valid_ff;
   rhd_pre_type        pre_ff, pre_in;

   rhd_item_type       item;
   logic               fire;
   logic [32:0]        dt_sum;
   logic [31:0]        dt_adv;
   logic [21:0]        ot_sum;
   logic [20:0]        ot_adv;
   logic [26:0]        restart_limit;
   logic signed [15:0] sl_base;
   logic signed [18:0] rot;
   logic [17:0]        mag;
   logic [17:0]        step_s;
   logic [25:0]        dur_us;

   assign item     = in_data.item;
   assign in_ready = !pre_valid_ff || out_ready;
   assign fire     = in_valid && in_ready;

   always_comb begin
      // timers advance first on every kind
      dt_sum = {1'b0, dt_ff} + 33'(item.elapsed);
      dt_adv = dt_ff;
      if (dt_on_ff) dt_adv = dt_sum[32] ? '1 : dt_sum[31:0];
      ot_sum = {1'b0, ot_ff} + 22'(item.elapsed);
      ot_adv = ot_ff;
      if (ot_on_ff) ot_adv = ot_sum[21] ? OFF_SAT : ot_sum[20:0];

      sl_in    = sl_ff;
      left_in  = left_ff;
      right_in = right_ff;
      hd_in    = hd_ff;
      hs_in    = hs_ff;
      hdur_in  = hdur_ff;
      dt_in    = dt_adv;
      dt_on_in = dt_on_ff;
      ot_in    = ot_adv;
      ot_on_in = ot_on_ff;

      restart_limit = 27'(27'(hdur_ff) * 27'(US_PER_MS)) + 27'(US_PER_S);
      sl_base = sl_ff;
      rot     = '0;
      mag     = '0;
      step_s  = '0;
      dur_us  = '0;
      pre_in  = '0;

      case (item.kind)
         KIND_TANK: begin
            left_in  = rhd_ramp(item.left, left_ff, in_data.step_a);
            right_in = rhd_ramp(item.right, right_ff, in_data.step_b);
         end
         KIND_RESET: begin
            sl_in   = '0;
            hd_in   = '0;
            hs_in   = '0;
            hdur_in = '0;
         end
         default: begin
            if (item.kind == KIND_BEGIN) begin
               // long stop since the last drive: restart the ramp from zero
               if (dt_adv > 32'(restart_limit)) sl_base = '0;
               hd_in    = item.target;
               hs_in    = item.max_out;
               hdur_in  = item.dur_ms;
               dt_in    = '0;
               dt_on_in = 1'b1;
            end
            sl_in = sl_base;
            rot   = {hd_in[17], hd_in};
            rot   = {item.gyro[17], item.gyro} - rot;
            mag   = rot[18] ? 18'(-rot) : rot[17:0];
            if (rot > ABORT_ERR || rot < -ABORT_ERR || ot_adv > 21'(US_PER_S)) begin
               pre_in.aborted = 1'b1;
            end else begin
               if (rot > OFF_ERR || rot < -OFF_ERR) begin
                  ot_on_in = 1'b1;
               end else begin
                  ot_in    = '0;
                  ot_on_in = 1'b0;
               end
               step_s = hs_in[15] ? in_data.step_b : in_data.step_a;
               sl_in  = rhd_ramp(hs_in, sl_base, step_s);
               dur_us = 26'(hdur_in) * 26'(US_PER_MS);
               if (32'(dur_us) > dt_in) begin
                  pre_in.active  = 1'b1;
                  pre_in.speed   = sl_in;
                  pre_in.mag     = (mag > 18'(CURVE_KNEE)) ? CURVE_KNEE + 11'd1 : mag[10:0];
                  pre_in.neg     = rot[18];
                  pre_in.rest_us = dur_us - dt_in[25:0];
               end
            end
         end
      endcase

      pre_in.left  = left_in;
      pre_in.right = right_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sl_ff        <= '0;
         left_ff      <= '0;
         right_ff     <= '0;
         hd_ff        <= '0;
         hs_ff        <= '0;
         hdur_ff      <= '0;
         dt_ff        <= '0;
         dt_on_ff     <= 1'b0;
         ot_ff        <= '0;
         ot_on_ff     <= 1'b0;
         pre_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            sl_ff    <= sl_in;
            left_ff  <= left_in;
            right_ff <= right_in;
            hd_ff    <= hd_in;
            hs_ff    <= hs_in;
            hdur_ff  <= hdur_in;
            dt_ff    <= dt_in;
            dt_on_ff <= dt_on_in;
            ot_ff    <= ot_in;
            ot_on_ff <= ot_on_in;
         end
         if (in_ready) pre_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) pre_ff <= pre_in;
   end

   assign out_valid = pre_valid_ff;
   assign out_data  = pre_ff;

endmodule

`default_nettype wire

// ===== design/rhd_finish.sv =====
`default_nettype none
// rhd_finish: curve scaling, remaining-time rounding and the result register.
// Depends on rhd_pkg and rhd_rsp_if.

module rhd_finish (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire rhd_pkg::rhd_pre_type in_data,
   output logic                      in_ready,
   rhd_rsp_if.source                 rsp_bus
);
   import rhd_pkg::*;

   logic               rsp_valid_ff;
   logic signed [15:0] speed_ff;
   logic signed [11:0] curve_ff, curve_in;
   logic signed [15:0] left_ff, right_ff;
   logic [15:0]        rem_ff, rem_in;
   logic               aborted_ff;
   logic [10:0]        curve_mag;

   assign in_ready = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      curve_mag = rhd_curve(in_data.mag);
      curve_in  = '0;
      rem_in    = '0;
      if (in_data.active) begin
         curve_in = in_data.neg ? -$signed({1'b0, curve_mag}) : $signed({1'b0, curve_mag});
         rem_in   = rhd_ceil_ms(in_data.rest_us);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (in_ready) begin
         rsp_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         speed_ff   <= in_data.speed;
         curve_ff   <= curve_in;
         left_ff    <= in_data.left;
         right_ff   <= in_data.right;
         rem_ff     <= rem_in;
         aborted_ff <= in_data.aborted;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.out_speed    = speed_ff;
   assign rsp_bus.out_curve    = curve_ff;
   assign rsp_bus.out_left     = left_ff;
   assign rsp_bus.out_right    = right_ff;
   assign rsp_bus.remaining_ms = rem_ff;
   assign rsp_bus.aborted      = aborted_ff;

endmodule

`default_nettype wire
